// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the block.
// No dependencies; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is low
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lbbs_pkg.sv =====
// Shared types and constants of the lightmap bilinear shader.
// No dependencies; used by the top level and its checker.
`default_nettype none

package lbbs_pkg;

    localparam int BLOCK_SIDE  = 16;
    localparam int SIDE_LOG2   = 4;
    localparam int LEVEL_SHIFT = 16 + 2;
    localparam int LEVEL_W     = 6;
    localparam int LUMEL_W     = 8;
    localparam int CELL_W      = 6;
    localparam int COORD_W     = 10;
    localparam int HALF_LANES  = 8;
    localparam int HALF_W      = HALF_LANES * LEVEL_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int MIP_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIP_LEVEL    = 3'd0,
        CFG_TEX_OFFSET_X = 3'd1,
        CFG_TEX_OFFSET_Y = 3'd2,
        CFG_TEX_MASK_X   = 3'd3,
        CFG_TEX_MASK_Y   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [LUMEL_W-1:0] corner_top_left;
        logic [LUMEL_W-1:0] corner_top_right;
        logic [LUMEL_W-1:0] corner_bottom_left;
        logic [LUMEL_W-1:0] corner_bottom_right;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
    } t_in;

    typedef struct packed {
        logic [HALF_W-1:0]  levels_first_half;
        logic [HALF_W-1:0]  levels_second_half;
        logic [COORD_W-1:0] surface_x;
        logic [COORD_W-1:0] surface_y;
        logic [COORD_W-1:0] texture_x;
        logic [COORD_W-1:0] texture_y;
        logic               last_row;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/lightmap_block_bilinear_shader.sv =====
// Lightmap cell bilinear shader: one cell in, one pixel-row result per cycle out.
// Depends on lbbs_pkg (types, constants, register indexes).
//
//  channel   | signals                              | carries
//  ----------+--------------------------------------+-------------------------------
//  cell in   | i_in_valid  o_in_ready  i_in_data    | four corner lumels, cell col/row
//  row out   | o_out_valid i_out_ready o_out_data   | row levels, coordinates, last
//  config    | i_cfg_we i_cfg_index i_cfg_data      | mip, texture offsets and masks
//
// A cell yields 16 >> mip rows (16, 8, 4 or 2), one per cycle from the row
// sequencer while the output is not stalled; the next cell is taken in the cycle
// the last row of the current one leaves the sequencer. The first row is offered
// after the row sequencer, row step, pixel lanes and output registers.
// Synchronous active-low reset clears the valid bits, busy flag and config registers.
// A stall on the output holds every stage; nothing is dropped or repeated.
`default_nettype none

module lightmap_block_bilinear_shader (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire lbbs_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output lbbs_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [lbbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lbbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lbbs_pkg::*;

    localparam int LANES  = 2 * HALF_LANES;
    localparam int ROW_W  = SIDE_LOG2;
    localparam int SIDE_W = SIDE_LOG2 + 1;
    localparam int SH_W   = 3;
    localparam int ACC_W  = LUMEL_W + 16 + 2;
    localparam int INT_W  = ACC_W + SIDE_LOG2 + 1;

    // configuration registers
    logic [MIP_W-1:0]   r_mip_level;
    logic [COORD_W-1:0] r_tex_offset_x;
    logic [COORD_W-1:0] r_tex_offset_y;
    logic [COORD_W-1:0] r_tex_mask_x;
    logic [COORD_W-1:0] r_tex_mask_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mip_level    <= '0;
            r_tex_offset_x <= '0;
            r_tex_offset_y <= '0;
            r_tex_mask_x   <= COORD_W'(255);
            r_tex_mask_y   <= COORD_W'(255);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIP_LEVEL:    r_mip_level    <= i_cfg_data[MIP_W-1:0];
                CFG_TEX_OFFSET_X: r_tex_offset_x <= i_cfg_data[COORD_W-1:0];
                CFG_TEX_OFFSET_Y: r_tex_offset_y <= i_cfg_data[COORD_W-1:0];
                CFG_TEX_MASK_X:   r_tex_mask_x   <= i_cfg_data[COORD_W-1:0];
                CFG_TEX_MASK_Y:   r_tex_mask_y   <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_busy;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;
    logic adv;
    logic in_acc;
    logic seq_last;

    // row sequencer (stage 1)
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        r_last_idx;
    logic [MIP_W-1:0]        r_mip;
    logic signed [ACC_W-1:0] r_left;
    logic signed [ACC_W-1:0] r_right;
    logic signed [ACC_W-1:0] r_dl;
    logic signed [ACC_W-1:0] r_dr;
    logic [COORD_W-1:0]      r_sx;
    logic [COORD_W-1:0]      r_sy0;

    // cell set-up from the incoming request
    logic [SH_W-1:0]         in_sh;
    logic [SIDE_W-1:0]       in_side;
    logic signed [ACC_W-1:0] in_tl;
    logic signed [ACC_W-1:0] in_tr;
    logic signed [ACC_W-1:0] in_bl;
    logic signed [ACC_W-1:0] in_br;

    assign adv        = !r_out_valid || i_out_ready;
    assign seq_last   = (r_row == r_last_idx);
    assign o_in_ready = !r_busy || (adv && seq_last);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        in_sh   = SH_W'(SIDE_LOG2) - SH_W'(r_mip_level);
        in_side = SIDE_W'(BLOCK_SIDE) >> r_mip_level;
        in_tl   = $signed({2'b00, i_in_data.corner_top_left, 16'h0000});
        in_tr   = $signed({2'b00, i_in_data.corner_top_right, 16'h0000});
        in_bl   = $signed({2'b00, i_in_data.corner_bottom_left, 16'h0000});
        in_br   = $signed({2'b00, i_in_data.corner_bottom_right, 16'h0000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (adv && seq_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row      <= '0;
            r_last_idx <= ROW_W'(in_side - SIDE_W'(1));
            r_mip      <= r_mip_level;
            r_left     <= in_tl;
            r_right    <= in_tr;
            r_dl       <= (in_bl - in_tl) >>> in_sh;
            r_dr       <= (in_br - in_tr) >>> in_sh;
            r_sx       <= COORD_W'(i_in_data.cell_col) << in_sh;
            r_sy0      <= COORD_W'(i_in_data.cell_row) << in_sh;
        end else if (adv && r_busy && !seq_last) begin
            // advance to the next pixel row
            r_row   <= r_row + ROW_W'(1);
            r_left  <= r_left + r_dl;
            r_right <= r_right + r_dr;
        end
    end

    // stage 2: row step and coordinates
    logic signed [ACC_W-1:0] r_s2_left;
    logic signed [ACC_W-1:0] r_s2_drow;
    logic [MIP_W-1:0]        r_s2_mip;
    logic                    r_s2_last;
    logic [COORD_W-1:0]      r_s2_sx;
    logic [COORD_W-1:0]      r_s2_sy;
    logic [COORD_W-1:0]      r_s2_tx;
    logic [COORD_W-1:0]      r_s2_ty;
    logic [SH_W-1:0]         cur_sh;
    logic [COORD_W-1:0]      cur_sy;

    always_comb begin
        cur_sh = SH_W'(SIDE_LOG2) - SH_W'(r_mip);
        cur_sy = r_sy0 + COORD_W'(r_row);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_left <= r_left;
            r_s2_drow <= (r_right - r_left) >>> cur_sh;
            r_s2_mip  <= r_mip;
            r_s2_last <= seq_last;
            r_s2_sx   <= r_sx;
            r_s2_sy   <= cur_sy;
            r_s2_tx   <= (r_sx + r_tex_offset_x) & r_tex_mask_x;
            r_s2_ty   <= (cur_sy + r_tex_offset_y) & r_tex_mask_y;
        end
    end

    // stage 3: one intensity per pixel lane
    logic signed [INT_W-1:0] n_s3_inten [LANES];
    logic signed [INT_W-1:0] r_s3_inten [LANES];
    logic [MIP_W-1:0]        r_s3_mip;
    logic                    r_s3_last;
    logic [COORD_W-1:0]      r_s3_sx;
    logic [COORD_W-1:0]      r_s3_sy;
    logic [COORD_W-1:0]      r_s3_tx;
    logic [COORD_W-1:0]      r_s3_ty;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_s3_inten[j] = INT_W'(r_s2_left) + INT_W'(r_s2_drow) * INT_W'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_inten <= n_s3_inten;
            r_s3_mip   <= r_s2_mip;
            r_s3_last  <= r_s2_last;
            r_s3_sx    <= r_s2_sx;
            r_s3_sy    <= r_s2_sy;
            r_s3_tx    <= r_s2_tx;
            r_s3_ty    <= r_s2_ty;
        end
    end

    // stage 4: clamp levels, blank lanes past the block side
    logic [LANES*LEVEL_W-1:0] n_levels;
    logic [SIDE_W-1:0]        s3_side;
    t_out                     r_out;

    always_comb begin
        s3_side = SIDE_W'(BLOCK_SIDE) >> r_s3_mip;
        for (int j = 0; j < LANES; j++) begin
            if (SIDE_W'(j) >= s3_side || r_s3_inten[j][INT_W-1]) begin
                n_levels[j*LEVEL_W +: LEVEL_W] = '0;
            end else if (|r_s3_inten[j][INT_W-2:LEVEL_SHIFT+LEVEL_W]) begin
                n_levels[j*LEVEL_W +: LEVEL_W] = '1;
            end else begin
                n_levels[j*LEVEL_W +: LEVEL_W] =
                    r_s3_inten[j][LEVEL_SHIFT+LEVEL_W-1:LEVEL_SHIFT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.levels_first_half  <= n_levels[HALF_W-1:0];
            r_out.levels_second_half <= n_levels[2*HALF_W-1:HALF_W];
            r_out.surface_x          <= r_s3_sx;
            r_out.surface_y          <= r_s3_sy;
            r_out.texture_x          <= r_s3_tx;
            r_out.texture_y          <= r_s3_ty;
            r_out.last_row           <= r_s3_last;
        end
    end

    // valid bits travel with the rows; hold all stages while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid  <= r_busy;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/lbbs_checker.sv =====
// Port-level checker for the lightmap bilinear shader, bound to the top level.
// Depends on lbbs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lbbs_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire lbbs_pkg::t_out o_out_data
);
    import lbbs_pkg::*;

    // a row left stalled stays offered, unchanged
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "row request dropped while stalled")
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data), "stalled row request changed")
    // no row may come out of reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "row offered straight after reset")
    // the last row index is side - 1, always odd, and sits in the low bits of surface_y
    `ASSERT_RST(a_last_odd, i_clk, i_rst_n, o_out_valid && o_out_data.last_row |-> o_out_data.surface_y[0], "last row on an even surface row")
    // surface column is the cell column scaled by a side of at least two
    `ASSERT_RST(a_sx_even, i_clk, i_rst_n, o_out_valid |-> !o_out_data.surface_x[0], "odd surface column")

endmodule

bind lightmap_block_bilinear_shader lbbs_checker u_lbbs_checker (.*);

`default_nettype wire

// ===== dv/lbbs_tb_pkg.sv =====
`timescale 1ns / 100ps
// Row predictor and scoreboard for the lightmap bilinear shader testbench.
// Depends on lbbs_pkg for the request and row types and the register indexes.

package lbbs_tb_pkg;

    import lbbs_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;

    class shaded_row_board;
        logic [MIP_W-1:0]   mip_level;
        logic [COORD_W-1:0] tex_offset_x;
        logic [COORD_W-1:0] tex_offset_y;
        logic [COORD_W-1:0] tex_mask_x;
        logic [COORD_W-1:0] tex_mask_y;
        t_out               rows_due[$];
        int                 mismatches;

        function new();
            mip_level    = '0;
            tex_offset_x = '0;
            tex_offset_y = '0;
            tex_mask_x   = COORD_W'(255);
            tex_mask_y   = COORD_W'(255);
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_MIP_LEVEL:    mip_level    = value[MIP_W-1:0];
                CFG_TEX_OFFSET_X: tex_offset_x = value;
                CFG_TEX_OFFSET_Y: tex_offset_y = value;
                CFG_TEX_MASK_X:   tex_mask_x   = value;
                CFG_TEX_MASK_Y:   tex_mask_y   = value;
                default: ;
            endcase
        endfunction

        // Work out every pixel row that one accepted cell request produces
        function void note_cell(t_in lm_req);
            int                  shift, side;
            int                  top_l, top_r, bot_l, bot_r;
            int                  step_l, step_r, edge_l, edge_r, step_px, inten, level;
            logic [2*HALF_W-1:0] lanes;
            logic [COORD_W-1:0]  sx, sy;
            t_out                row;
            shift  = SIDE_LOG2 - int'(mip_level);
            side   = BLOCK_SIDE >> mip_level;
            top_l  = int'(lm_req.corner_top_left) << 16;
            top_r  = int'(lm_req.corner_top_right) << 16;
            bot_l  = int'(lm_req.corner_bottom_left) << 16;
            bot_r  = int'(lm_req.corner_bottom_right) << 16;
            step_l = (bot_l - top_l) >>> shift;
            step_r = (bot_r - top_r) >>> shift;
            sx     = COORD_W'(int'(lm_req.cell_col) * side);
            for (int i = 0; i < side; i++) begin
                edge_l  = top_l + i * step_l;
                edge_r  = top_r + i * step_r;
                step_px = (edge_r - edge_l) >>> shift;
                // slots past the block side stay zero
                lanes   = '0;
                for (int j = 0; j < side; j++) begin
                    inten = edge_l + j * step_px;
                    level = inten >>> LEVEL_SHIFT;
                    if (level < 0) level = 0;
                    if (level > LEVEL_MAX) level = LEVEL_MAX;
                    lanes[j*LEVEL_W +: LEVEL_W] = LEVEL_W'(level);
                end
                sy = COORD_W'(int'(lm_req.cell_row) * side + i);
                row.levels_first_half  = lanes[HALF_W-1:0];
                row.levels_second_half = lanes[2*HALF_W-1:HALF_W];
                row.surface_x          = sx;
                row.surface_y          = sy;
                // sum wraps in 10 bits before the mask
                row.texture_x          = COORD_W'(sx + tex_offset_x) & tex_mask_x;
                row.texture_y          = COORD_W'(sy + tex_offset_y) & tex_mask_y;
                row.last_row           = (i == side - 1);
                rows_due.push_back(row);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
        endfunction

        function void compare_field(string name, logic [HALF_W-1:0] want,
                                    logic [HALF_W-1:0] got);
            if (want !== got) flag($sformatf("%s expected %h got %h", name, want, got));
        endfunction

        function void check_row(t_out got);
            t_out want;
            if (rows_due.size() == 0) begin
                flag($sformatf("row with no cell pending: %h", got));
                return;
            end
            want = rows_due.pop_front();
            compare_field("levels_first_half", want.levels_first_half, got.levels_first_half);
            compare_field("levels_second_half", want.levels_second_half,
                          got.levels_second_half);
            compare_field("surface_x", HALF_W'(want.surface_x), HALF_W'(got.surface_x));
            compare_field("surface_y", HALF_W'(want.surface_y), HALF_W'(got.surface_y));
            compare_field("texture_x", HALF_W'(want.texture_x), HALF_W'(got.texture_x));
            compare_field("texture_y", HALF_W'(want.texture_y), HALF_W'(got.texture_y));
            compare_field("last_row", HALF_W'(want.last_row), HALF_W'(got.last_row));
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void check_drained();
            if (rows_due.size() != 0) flag($sformatf("%0d rows never arrived", rows_due.size()));
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the lightmap bilinear shader testbench: clock, reset, request and row
// drivers, register writes and the run sequence. Depends on lbbs_pkg and lbbs_tb_pkg.

module tb_top;

    import lbbs_pkg::*;
    import lbbs_tb_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int BLOCK_CELLS     = 42;
    localparam int PRESSURE_CELLS  = 30;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in                   in_data     = '0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out                  out_data;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    hold_req_seq = 0;
    int                    stall_cycles = 0;
    int                    tx_pct [3] = '{14, 84, 0};
    int                    rx_pct [3] = '{84, 14, 0};
    t_in                   directed_cells [6];
    shaded_row_board       board;

    lightmap_block_bilinear_shader DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [CFG_DATA_W-1:0] pick_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [LUMEL_W-1:0] pick_lumel();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            default: return LUMEL_W'($urandom);
        endcase
    endfunction

    function automatic t_in random_cell();
        t_in lm_req;
        lm_req.corner_top_left     = pick_lumel();
        lm_req.corner_top_right    = pick_lumel();
        lm_req.corner_bottom_left  = pick_lumel();
        lm_req.corner_bottom_right = pick_lumel();
        // mostly inside the lightmap, now and then anywhere in 6 bits
        lm_req.cell_col = ($urandom_range(7) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(32));
        lm_req.cell_row = ($urandom_range(7) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(32));
        return lm_req;
    endfunction

    task automatic send_cell(input t_in lm_req);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= lm_req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        board.note_cell(lm_req);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
        board.set_reg(index, value);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] mip_word,
                                  input logic [CFG_DATA_W-1:0] off_x,
                                  input logic [CFG_DATA_W-1:0] off_y,
                                  input logic [CFG_DATA_W-1:0] mask_x,
                                  input logic [CFG_DATA_W-1:0] mask_y);
        logic [CFG_DATA_W-1:0] values [5];
        values = '{mip_word, off_x, off_y, mask_x, mask_y};
        for (int k = 0; k <= CFG_TEX_MASK_Y; k++) write_reg(CFG_IDX_W'(k), values[k]);
        // an index past the register file must change nothing
        write_reg(CFG_IDX_W'($urandom_range(CFG_TEX_MASK_Y + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Row receiver: random back-pressure, plus a long hold-off on request
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req_seq != hold_seen) begin
                hold_seen = hold_req_seq;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) board.check_row(out_data);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        board = new();
        directed_cells[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0};
        directed_cells[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 6'd63, 6'd63};
        directed_cells[2] = '{8'd255, 8'd0, 8'd0, 8'd0, 6'd32, 6'd32};
        directed_cells[3] = '{8'd0, 8'd255, 8'd255, 8'd0, 6'd0, 6'd63};
        directed_cells[4] = '{8'd0, 8'd0, 8'd0, 8'd255, 6'd63, 6'd0};
        directed_cells[5] = '{8'd128, 8'd64, 8'd32, 8'd16, 6'd31, 6'd33};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells at every mip level, offsets and masks at all ones, zero and other set values
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: apply_settings(CFG_DATA_W'({$urandom, MIP_W'(m)}), '1, '1, '1, '1);
                1: apply_settings(CFG_DATA_W'({$urandom, MIP_W'(m)}), '0, '0,
                                  CFG_DATA_W'(255), CFG_DATA_W'(255));
                2: apply_settings(CFG_DATA_W'({$urandom, MIP_W'(m)}), CFG_DATA_W'(512),
                                  CFG_DATA_W'(1), '0, '0);
                default: apply_settings(CFG_DATA_W'({$urandom, MIP_W'(m)}), '1, '0, '1,
                                        CFG_DATA_W'(1));
            endcase
            foreach (directed_cells[k]) send_cell(directed_cells[k]);
            in_valid <= 1'b0;
            drain();
        end

        // Random cells under each idling pattern, fresh settings per block
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = tx_pct[p];
            rx_idle_pct <= rx_pct[p];
            for (int b = 0; b < 3; b++) begin
                apply_settings(CFG_DATA_W'({$urandom, MIP_W'(b + p)}), pick_word(),
                               pick_word(), pick_word(), pick_word());
                for (int k = 0; k < BLOCK_CELLS; k++) send_cell(random_cell());
                in_valid <= 1'b0;
                drain();
            end
        end

        // Hold the receiver off while requests keep coming, so the input stalls
        apply_settings(CFG_DATA_W'({$urandom, MIP_W'(0)}), pick_word(), pick_word(),
                       pick_word(), pick_word());
        hold_req_seq <= hold_req_seq + 1;
        for (int k = 0; k < PRESSURE_CELLS; k++) send_cell(random_cell());
        in_valid <= 1'b0;
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.check_drained();
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
